// ----- design/qfir_pkg.sv -----
// Shared constants, types and control structs of the Q15 FIR filter.
// No dependencies; every other file of the block imports this package.
package qfir_pkg;

   // Filter geometry
   localparam int TAPS           = 32;
   localparam int SAMPLE_W       = 16;
   localparam int COEF_W         = 16;
   localparam int PROD_W         = SAMPLE_W + COEF_W;
   localparam int COEFS_PER_WORD = 4;
   localparam int NUM_COEF_WORDS = 8;

   // Adder tree depth, leaves padded up to a power of two
   localparam int LEVELS = (TAPS > 1) ? $clog2(TAPS) : 1;
   localparam int LEAVES = 1 << LEVELS;
   localparam int ACC_W  = PROD_W + LEVELS;

   // Rounding and saturation
   localparam int QSHIFT     = 15;
   localparam int ROUND_BIAS = 1 << (QSHIFT - 1);
   localparam int SAT_MAX    = 32767;
   localparam int SAT_MIN    = -32768;

   // Register port
   localparam int CSR_DATA_W  = 64;
   localparam int WORD_IDX_W  = $clog2(NUM_COEF_WORDS);
   localparam int BYTE_OFF_W  = $clog2(CSR_DATA_W / 8);
   localparam int CSR_ADDR_W  = WORD_IDX_W + BYTE_OFF_W;

   typedef logic signed [SAMPLE_W-1:0] sample_type;
   typedef logic signed [COEF_W-1:0]   coef_type;
   typedef logic signed [PROD_W-1:0]   prod_type;
   typedef logic signed [ACC_W-1:0]    acc_type;
   typedef logic [CSR_DATA_W-1:0]      coef_word_type;
   typedef logic [CSR_ADDR_W-1:0]      csr_addr_type;
   typedef logic [WORD_IDX_W-1:0]      word_idx_type;

   // Control handed to each tap cell
   typedef struct packed {
      logic load;   // a beat is taken this cycle
      logic clear;  // history is zero for this beat
   } cell_ctrl_type;

endpackage

// ----- design/qfir_stream_if.sv -----
// Valid/ready stream interfaces for sample beats and filtered beats.
// Depends on qfir_pkg for the payload types.
interface qfir_req_if;
   import qfir_pkg::*;

   logic       valid;
   logic       ready;
   sample_type sample;
   logic       block_start;

   modport source (output valid, output sample, output block_start, input ready);
   modport sink   (input valid, input sample, input block_start, output ready);
endinterface

interface qfir_rsp_if;
   import qfir_pkg::*;

   logic       valid;
   logic       ready;
   sample_type filtered;

   modport source (output valid, output filtered, input ready);
   modport sink   (input valid, input filtered, output ready);
endinterface

// ----- design/qfir_tap_cell.sv -----
// One tap of the FIR chain: holds a delay line entry and its registered product.
// Depends on qfir_pkg.
module qfir_tap_cell (
   input  logic                   clock,
   input  logic                   reset,
   input  qfir_pkg::cell_ctrl_type ctrl,
   input  qfir_pkg::sample_type   tap_in,
   input  qfir_pkg::coef_type     coef,
   output qfir_pkg::sample_type   hist_out,
   output qfir_pkg::prod_type     prod_out
);
   import qfir_pkg::*;

   sample_type hist_ff;
   sample_type hist_in;
   prod_type   prod_ff;
   prod_type   prod_in;

   // window value of this tap for the current beat
   always_comb begin
      hist_in = ctrl.clear ? '0 : tap_in;
      prod_in = PROD_W'(hist_in) * PROD_W'(coef);
   end

   // delay entry shifts only on a taken beat
   always_ff @(posedge clock) begin
      if (reset) begin
         hist_ff <= '0;
      end else if (ctrl.load) begin
         hist_ff <= hist_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.load) begin
         prod_ff <= prod_in;
      end
   end

   assign hist_out = hist_ff;
   assign prod_out = prod_ff;

endmodule

// ----- design/qfir_add_tree.sv -----
// Registered binary adder tree summing the tap products, one level per cycle while advance is high.
// Depends on qfir_pkg.
module qfir_add_tree (
   input  logic               clock,
   input  logic               reset,
   input  logic               advance,
   input  logic               valid_in,
   input  qfir_pkg::prod_type prod_in [qfir_pkg::TAPS],
   output logic               valid_out,
   output qfir_pkg::acc_type  sum_out
);
   import qfir_pkg::*;

   acc_type leaf [LEAVES];
   acc_type node_ff [LEVELS][LEAVES/2];
   logic    valid_ff [LEVELS];

   // sign-extended leaves, padding taps read as zero
   genvar gi, gl;
   generate
      for (gi = 0; gi < LEAVES; gi++) begin : g_leaf
         if (gi < TAPS) begin : g_used
            assign leaf[gi] = ACC_W'(prod_in[gi]);
         end else begin : g_pad
            assign leaf[gi] = '0;
         end
      end

      for (gl = 0; gl < LEVELS; gl++) begin : g_level
         for (gi = 0; gi < (LEAVES >> (gl + 1)); gi++) begin : g_node
            if (gl == 0) begin : g_first
               always_ff @(posedge clock) begin
                  if (advance) begin
                     node_ff[gl][gi] <= leaf[2*gi] + leaf[2*gi+1];
                  end
               end
            end else begin : g_inner
               always_ff @(posedge clock) begin
                  if (advance) begin
                     node_ff[gl][gi] <= node_ff[gl-1][2*gi] + node_ff[gl-1][2*gi+1];
                  end
               end
            end
         end

         // valid follows the data through each level
         always_ff @(posedge clock) begin
            if (reset) begin
               valid_ff[gl] <= 1'b0;
            end else if (advance) begin
               valid_ff[gl] <= (gl == 0) ? valid_in : valid_ff[(gl == 0) ? 0 : gl-1];
            end
         end
      end
   endgenerate

   assign valid_out = valid_ff[LEVELS-1];
   assign sum_out   = node_ff[LEVELS-1][0];

endmodule

// ----- design/qfir_round_sat.sv -----
// Output stage: round by half an LSB, shift right by 15, saturate to 16 bits.
// Holds the result beat in the output register. Depends on qfir_pkg.
module qfir_round_sat (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 advance,
   input  logic                 valid_in,
   input  qfir_pkg::acc_type    sum_in,
   output logic                 valid_out,
   output qfir_pkg::sample_type filtered_out
);
   import qfir_pkg::*;

   localparam int BIASED_W = ACC_W + 1;
   localparam int SHIFT_W  = BIASED_W - QSHIFT;

   logic signed [BIASED_W-1:0] biased;
   logic signed [SHIFT_W-1:0]  shifted;
   sample_type                 filtered_in;
   sample_type                 filtered_ff;
   logic                       valid_ff;

   // round, floor shift, clamp
   always_comb begin
      biased  = BIASED_W'(sum_in) + BIASED_W'(ROUND_BIAS);
      shifted = SHIFT_W'(biased >>> QSHIFT);
      if (shifted > SHIFT_W'(SAT_MAX)) begin
         filtered_in = SAMPLE_W'(SAT_MAX);
      end else if (shifted < SHIFT_W'(SAT_MIN)) begin
         filtered_in = SAMPLE_W'(SAT_MIN);
      end else begin
         filtered_in = shifted[SAMPLE_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         filtered_ff <= filtered_in;
      end
   end

   assign valid_out    = valid_ff;
   assign filtered_out = filtered_ff;

endmodule

// ----- design/q15_fir_filter_rounding_unit.sv -----
// Q15 FIR filter, 32 taps, direct form with rounding and saturation. One sample
// beat is taken every clock while the output is not stalled, and one filtered
// beat leaves per sample. When a sample beat is taken, the product registers
// load on that edge, then the five adder tree levels and the output register
// follow. The rate is set by the 32 tap cells each doing one 16x16 multiply per
// cycle while the pipeline advances. A stalled output holds the whole pipeline.
// Coefficients are eight 64-bit registers at byte addresses 8*i, four taps per
// word, lowest tap in the low bits; write them only while the filter is idle.
module q15_fir_filter_rounding_unit (
   input  logic                    clock,
   input  logic                    reset,
   qfir_req_if.sink                req_bus,
   qfir_rsp_if.source              rsp_bus,
   input  logic                    psel,
   input  logic                    penable,
   input  logic                    pwrite,
   input  qfir_pkg::csr_addr_type  paddr,
   input  qfir_pkg::coef_word_type pwdata,
   output qfir_pkg::coef_word_type prdata,
   output logic                    pready
);
   import qfir_pkg::*;

   coef_word_type coef_ff [NUM_COEF_WORDS];
   word_idx_type  word_idx;
   logic          csr_write;

   logic          advance;
   logic          accept;
   logic          prod_valid_ff;
   cell_ctrl_type head_ctrl;
   cell_ctrl_type tail_ctrl;
   sample_type    hand [TAPS];
   prod_type      prod [TAPS];
   logic          tree_valid;
   acc_type       tree_sum;

   // coefficient registers
   assign word_idx  = paddr[CSR_ADDR_W-1:BYTE_OFF_W];
   assign csr_write = psel && penable && pwrite;
   assign pready    = 1'b1;
   assign prdata    = coef_ff[word_idx];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_COEF_WORDS; i++) begin
            coef_ff[i] <= '0;
         end
      end else if (csr_write) begin
         coef_ff[word_idx] <= pwdata;
      end
   end

   // whole pipeline moves unless the output beat is stalled
   assign advance       = !rsp_bus.valid || rsp_bus.ready;
   assign req_bus.ready = advance;
   assign accept        = req_bus.valid && advance;

   // beat valid alongside the product registers
   always_ff @(posedge clock) begin
      if (reset) begin
         prod_valid_ff <= 1'b0;
      end else if (advance) begin
         prod_valid_ff <= accept;
      end
   end

   // the newest sample is never cleared; older taps see zero on block start
   assign head_ctrl = '{load: accept, clear: 1'b0};
   assign tail_ctrl = '{load: accept, clear: req_bus.block_start};

   genvar gk;
   generate
      for (gk = 0; gk < TAPS; gk++) begin : g_tap
         if (gk == 0) begin : g_head
            qfir_tap_cell u_cell (
               .clock    (clock),
               .reset    (reset),
               .ctrl     (head_ctrl),
               .tap_in   (req_bus.sample),
               .coef     (coef_ff[gk / COEFS_PER_WORD]
                            [(gk % COEFS_PER_WORD) * COEF_W +: COEF_W]),
               .hist_out (hand[gk]),
               .prod_out (prod[gk])
            );
         end else begin : g_tail
            qfir_tap_cell u_cell (
               .clock    (clock),
               .reset    (reset),
               .ctrl     (tail_ctrl),
               .tap_in   (hand[gk-1]),
               .coef     (coef_ff[gk / COEFS_PER_WORD]
                            [(gk % COEFS_PER_WORD) * COEF_W +: COEF_W]),
               .hist_out (hand[gk]),
               .prod_out (prod[gk])
            );
         end
      end
   endgenerate

   // sum of products
   qfir_add_tree u_tree (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .valid_in  (prod_valid_ff),
      .prod_in   (prod),
      .valid_out (tree_valid),
      .sum_out   (tree_sum)
   );

   // rounding, saturation and the output register
   qfir_round_sat u_round (
      .clock        (clock),
      .reset        (reset),
      .advance      (advance),
      .valid_in     (tree_valid),
      .sum_in       (tree_sum),
      .valid_out    (rsp_bus.valid),
      .filtered_out (rsp_bus.filtered)
   );

endmodule

// ----- verif/qfir_response_checker.sv -----
// Scoreboard for the Q15 FIR filter: watches the sample, filtered and register ports.
// It predicts each filtered beat and compares it with what the filter returns.
// Depends on qfir_pkg for the widths, types and rounding constants.
module qfir_response_checker
   import qfir_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   // sample channel
   input  logic          req_valid,
   input  logic          req_ready,
   input  sample_type    req_sample,
   input  logic          req_block_start,
   // filtered channel
   input  logic          rsp_valid,
   input  logic          rsp_ready,
   input  sample_type    rsp_filtered,
   // register port
   input  logic          psel,
   input  logic          penable,
   input  logic          pwrite,
   input  logic          pready,
   input  csr_addr_type  paddr,
   input  coef_word_type pwdata,
   // status for the test top
   output int unsigned   failures,
   output int unsigned   pending,
   output int unsigned   checked
);

   localparam int HIST_DEPTH = TAPS - 1;

   coef_word_type coef_shadow [NUM_COEF_WORDS];
   sample_type    history [HIST_DEPTH];
   sample_type    filtered_due [$];
   int unsigned   fail_total;
   int unsigned   compare_total;

   // Sum of products over the current sample and the history, rounded,
   // floor-shifted and clipped to int16
   function automatic sample_type fir_output(input sample_type x);
      longint   acc;
      longint   y;
      coef_type c;
      acc = 0;
      for (int k = 0; k < TAPS; k++) begin
         c = coef_shadow[k / COEFS_PER_WORD][COEF_W * (k % COEFS_PER_WORD) +: COEF_W];
         if (k == 0) begin
            acc += longint'(x) * longint'(c);
         end else begin
            acc += longint'(history[k-1]) * longint'(c);
         end
      end
      y = (acc + ROUND_BIAS) >>> QSHIFT;
      if (y > SAT_MAX) begin
         y = SAT_MAX;
      end
      if (y < SAT_MIN) begin
         y = SAT_MIN;
      end
      return sample_type'(y[SAMPLE_W-1:0]);
   endfunction

   always @(posedge clock) begin
      sample_type want;
      if (reset) begin
         for (int w = 0; w < NUM_COEF_WORDS; w++) begin
            coef_shadow[w] = '0;
         end
         for (int j = 0; j < HIST_DEPTH; j++) begin
            history[j] = '0;
         end
         filtered_due.delete();
         fail_total    = 0;
         compare_total = 0;
      end else begin
         // coefficient writes land in the shadow bank
         if (psel && penable && pwrite && pready) begin
            coef_shadow[paddr[CSR_ADDR_W-1 -: WORD_IDX_W]] = pwdata;
         end

         // filtered beat: compare with the oldest prediction
         if (rsp_valid && rsp_ready) begin
            compare_total++;
            if (filtered_due.size() == 0) begin
               $error("filtered beat %0d arrived with no sample outstanding", rsp_filtered);
               fail_total++;
            end else begin
               want = filtered_due.pop_front();
               if (rsp_filtered !== want) begin
                  $error("filtered mismatch: expected %0d, actual %0d", want, rsp_filtered);
                  fail_total++;
               end
            end
         end

         // sample beat: clear on block start, predict, then shift the history
         if (req_valid && req_ready) begin
            if (req_block_start) begin
               for (int j = 0; j < HIST_DEPTH; j++) begin
                  history[j] = '0;
               end
            end
            filtered_due.push_back(fir_output(req_sample));
            for (int j = HIST_DEPTH - 1; j > 0; j--) begin
               history[j] = history[j-1];
            end
            history[0] = req_sample;
         end
      end
      failures <= fail_total;
      pending  <= filtered_due.size();
      checked  <= compare_total;
   end

endmodule

// ----- verif/q15_fir_filter_rounding_unit_test.sv -----
// Test top for q15_fir_filter_rounding_unit: clock, reset, sample and register stimulus.
// Prediction and comparison sit in qfir_response_checker; uses qfir_pkg and the
// qfir_req_if / qfir_rsp_if stream interfaces.
module q15_fir_filter_rounding_unit_test;
   import qfir_pkg::*;

   localparam int RANDOM_ITEMS  = 1750;
   localparam int NUM_PHASES    = 10;
   localparam int SETTLE_CYCLES = 12;
   localparam int DRAIN_CYCLES  = 20;
   localparam int CYCLE_LIMIT   = 500000;

   typedef enum int {COEF_ZERO, COEF_SMALL, COEF_FULL, COEF_SPARSE, COEF_MAX, COEF_MIN}
      coef_style_e;
   typedef enum int {SAMP_FULL, SAMP_SMALL, SAMP_EXTREME, SAMP_HOLD} sample_style_e;
   typedef enum int {STALL_NONE, STALL_HALF, STALL_HEAVY, STALL_PERIODIC} stall_mode_e;
   typedef coef_word_type coef_bank_t [NUM_COEF_WORDS];

   logic          clock;
   logic          reset;
   logic          psel;
   logic          penable;
   logic          pwrite;
   csr_addr_type  paddr;
   coef_word_type pwdata;
   coef_word_type prdata;
   logic          pready;

   int unsigned   fail_count;
   int unsigned   pending_count;
   int unsigned   checked_count;
   int unsigned   cycle_count;

   int            burst_left;
   int unsigned   sent_count;
   int unsigned   setting_count;
   sample_type    last_sample;

   qfir_req_if req_bus ();
   qfir_rsp_if rsp_bus ();

   q15_fir_filter_rounding_unit u_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   qfir_response_checker u_checker (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_bus.valid),
      .req_ready       (req_bus.ready),
      .req_sample      (req_bus.sample),
      .req_block_start (req_bus.block_start),
      .rsp_valid       (rsp_bus.valid),
      .rsp_ready       (rsp_bus.ready),
      .rsp_filtered    (rsp_bus.filtered),
      .psel            (psel),
      .penable         (penable),
      .pwrite          (pwrite),
      .pready          (pready),
      .paddr           (paddr),
      .pwdata          (pwdata),
      .failures        (fail_count),
      .pending         (pending_count),
      .checked         (checked_count)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Run-length watchdog
   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("timeout after %0d cycles", cycle_count);
      $display("FAILURE");
      $finish;
   end

   // Receiver back-pressure: modes of random length, each with its own stall pattern
   initial begin
      stall_mode_e mode;
      int          mode_left;
      int unsigned tick;
      rsp_bus.ready = 1'b0;
      mode      = STALL_NONE;
      mode_left = 0;
      tick      = 0;
      forever begin
         @(posedge clock);
         if (mode_left == 0) begin
            mode      = stall_mode_e'($urandom_range(0, 3));
            mode_left = $urandom_range(32, 400);
         end
         mode_left--;
         tick++;
         case (mode)
            STALL_NONE:  rsp_bus.ready <= 1'b1;
            STALL_HALF:  rsp_bus.ready <= ($urandom_range(0, 1) == 1);
            STALL_HEAVY: rsp_bus.ready <= ($urandom_range(0, 3) == 0);
            default:     rsp_bus.ready <= ((tick % 11) < 4);
         endcase
      end
   end

   // One sample beat; gaps fall between bursts of random length
   task automatic send_sample(input sample_type s, input logic start);
      int gap;
      if (burst_left == 0) begin
         if ($urandom_range(0, 7) == 0) begin
            gap = $urandom_range(10, 25);
         end else begin
            gap = $urandom_range(0, 3);
         end
         if (gap > 0) begin
            req_bus.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = ($urandom_range(0, 9) == 0) ? 200 : $urandom_range(1, 48);
      end
      req_bus.valid       <= 1'b1;
      req_bus.sample      <= s;
      req_bus.block_start <= start;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      burst_left--;
      sent_count++;
   endtask

   // Stop sending and wait until every filtered beat is back
   task automatic drain_filter();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Setup then access cycle; psel stays high for back-to-back writes
   task automatic write_coef_word(input word_idx_type idx, input coef_word_type value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, {BYTE_OFF_W{1'b0}}};
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
   endtask

   task automatic program_coefs(input coef_bank_t bank);
      for (int w = 0; w < NUM_COEF_WORDS; w++) begin
         write_coef_word(word_idx_type'(w), bank[w]);
      end
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      setting_count++;
   endtask

   function automatic coef_bank_t make_bank(input coef_style_e style);
      coef_bank_t bank;
      coef_type   c;
      for (int w = 0; w < NUM_COEF_WORDS; w++) begin
         for (int i = 0; i < COEFS_PER_WORD; i++) begin
            case (style)
               COEF_ZERO:   c = '0;
               COEF_SMALL:  c = coef_type'($urandom) >>> $urandom_range(4, 15);
               COEF_FULL:   c = coef_type'($urandom);
               COEF_SPARSE: c = ($urandom_range(0, 5) == 0) ? coef_type'($urandom) : '0;
               COEF_MAX:    c = coef_type'(SAT_MAX);
               default:     c = coef_type'(SAT_MIN);
            endcase
            bank[w][COEF_W * i +: COEF_W] = c;
         end
      end
      return bank;
   endfunction

   function automatic sample_type next_sample(input sample_style_e style, input sample_type prev);
      case (style)
         SAMP_FULL:  return sample_type'($urandom);
         SAMP_SMALL: return sample_type'($urandom) >>> $urandom_range(6, 15);
         SAMP_EXTREME: begin
            case ($urandom_range(0, 4))
               0:       return sample_type'(SAT_MAX);
               1:       return sample_type'(SAT_MIN);
               2:       return sample_type'(0);
               3:       return sample_type'(-1);
               default: return sample_type'(1);
            endcase
         end
         default:    return prev;
      endcase
   endfunction

   // Main stimulus
   initial begin
      coef_bank_t    bank;
      coef_style_e   phase_styles [6];
      coef_style_e   style_now;
      sample_style_e run_style;
      sample_type    s;
      logic          start;
      int            start_odds;
      int            left;
      int            run;

      reset               = 1'b1;
      psel                = 1'b0;
      penable             = 1'b0;
      pwrite              = 1'b0;
      paddr               = '0;
      pwdata              = '0;
      req_bus.valid       = 1'b0;
      req_bus.sample      = '0;
      req_bus.block_start = 1'b0;
      burst_left          = 0;
      sent_count          = 0;
      setting_count       = 0;
      last_sample         = '0;
      phase_styles = '{COEF_MIN, COEF_SMALL, COEF_FULL, COEF_SPARSE, COEF_MAX, COEF_SMALL};

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // coefficients straight out of reset are all zero
      send_sample(sample_type'(SAT_MAX), 1'b1);
      send_sample(sample_type'(SAT_MIN), 1'b0);
      send_sample(sample_type'(-1), 1'b0);
      drain_filter();

      // tap 0 = 1 LSB: rounding at the half-way points
      bank = make_bank(COEF_ZERO);
      bank[0] = 64'h1;
      program_coefs(bank);
      send_sample(sample_type'(16384), 1'b1);
      send_sample(sample_type'(16383), 1'b0);
      send_sample(sample_type'(-16384), 1'b0);
      send_sample(sample_type'(-16385), 1'b0);
      send_sample(sample_type'(SAT_MAX), 1'b0);
      send_sample(sample_type'(SAT_MIN), 1'b0);
      drain_filter();

      // every tap at full positive scale: clipping both ways, block start clears
      program_coefs(make_bank(COEF_MAX));
      send_sample(sample_type'(SAT_MAX), 1'b1);
      send_sample(sample_type'(SAT_MAX), 1'b0);
      send_sample(sample_type'(SAT_MAX), 1'b0);
      send_sample(sample_type'(SAT_MIN), 1'b1);
      send_sample(sample_type'(SAT_MIN), 1'b0);
      send_sample(sample_type'(SAT_MIN), 1'b0);
      send_sample(sample_type'(0), 1'b1);
      drain_filter();

      // every tap at full negative scale
      program_coefs(make_bank(COEF_MIN));
      send_sample(sample_type'(SAT_MIN), 1'b1);
      send_sample(sample_type'(SAT_MIN), 1'b0);
      send_sample(sample_type'(SAT_MAX), 1'b1);
      send_sample(sample_type'(SAT_MAX), 1'b0);
      send_sample(sample_type'(SAT_MAX), 1'b0);

      // random phases, one coefficient setting each
      for (int p = 0; p < NUM_PHASES; p++) begin
         drain_filter();
         style_now = (p < 6) ? phase_styles[p] : coef_style_e'($urandom_range(1, 3));
         program_coefs(make_bank(style_now));
         start_odds = $urandom_range(6, 80);
         left       = RANDOM_ITEMS / NUM_PHASES;
         while (left > 0) begin
            run_style = sample_style_e'($urandom_range(0, 3));
            run       = $urandom_range(8, 64);
            for (int n = 0; n < run && left > 0; n++) begin
               s = next_sample((run_style == SAMP_HOLD && n == 0) ? SAMP_EXTREME : run_style,
                               last_sample);
               start = ($urandom_range(1, start_odds) == 1);
               send_sample(s, start);
               last_sample = s;
               left--;
            end
         end
      end

      drain_filter();
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("%0d samples sent under %0d coefficient settings, %0d filtered beats compared",
               sent_count, setting_count, checked_count);
      if (fail_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

// ----- files.f -----
design/qfir_pkg.sv
design/qfir_stream_if.sv
design/qfir_tap_cell.sv
design/qfir_add_tree.sv
design/qfir_round_sat.sv
design/q15_fir_filter_rounding_unit.sv
verif/qfir_response_checker.sv
verif/q15_fir_filter_rounding_unit_test.sv
